>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the list manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

>>> rtl/dll_pkg.sv
// Shared constants and payload types of the doubly linked list manager.
package dll_pkg;

   localparam int NODE_W  = 8;
   localparam int COUNT_W = 9;
   localparam int MODE_W  = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] anchor;
      logic              at_head;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [NODE_W-1:0]  next_node;
      logic               next_valid;
      logic [NODE_W-1:0]  prev_node;
      logic               prev_valid;
      logic [NODE_W-1:0]  head_node;
      logic               head_valid;
      logic [NODE_W-1:0]  tail_node;
      logic               tail_valid;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

>>> rtl/dll_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
interface dll_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/dll_node_ram.sv
// Node table RAM: one write port, one read port, registered read data.
module dll_node_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/doubly_linked_list_manager.sv
// Doubly linked list manager: node table in one RAM, read-modify-write sequencer.
// Each request passes S_NODE, S_DONE and S_HOLD; an insert or delete that touches
// neighbours reads them first (S_LEFT, S_RIGHT), then writes back (S_WR_L, S_WR_R, S_WR_N).
// A new request is taken only in S_IDLE; a waiting result holds only the next one.
// Reset: synchronous; a clearing pass sweeps every node RAM entry first.
`include "assert_macros.svh"

module doubly_linked_list_manager #(
   parameter int NODES = 256
) (
   input  logic       clock,
   input  logic       reset,
   dll_chan_if.sink   req_bus,
   dll_chan_if.source rsp_bus
);

   import dll_pkg::*;

   localparam int IW  = $clog2(NODES);
   localparam int XW  = (IW > NODE_W) ? IW : NODE_W;
   localparam int CW  = $clog2(NODES + 1);
   localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] idx;
   } link_type;

   typedef struct packed {
      logic     listed;
      link_type next;
      link_type prev;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_NODE  = 10'b0000000100,
      S_LEFT  = 10'b0000001000,
      S_RIGHT = 10'b0000010000,
      S_WR_L  = 10'b0000100000,
      S_WR_R  = 10'b0001000000,
      S_WR_N  = 10'b0010000000,
      S_DONE  = 10'b0100000000,
      S_HOLD  = 10'b1000000000
   } state_type;

   function automatic logic in_pool(input logic [NODE_W-1:0] n);
      logic [XW:0] w;
      w = (XW + 1)'(n);
      return w < (XW + 1)'(NODES);
   endfunction

   function automatic logic [IW-1:0] to_idx(input logic [NODE_W-1:0] n);
      logic [XW-1:0] w;
      w = XW'(n);
      return w[IW-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] to_fld(input logic [IW-1:0] i);
      logic [XW-1:0] w;
      w = XW'(i);
      return w[NODE_W-1:0];
   endfunction

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   entry_type     node_ent_ff, node_ent_in;
   entry_type     left_ent_ff, left_ent_in;
   entry_type     right_ent_ff, right_ent_in;
   logic [IW-1:0] left_idx_ff, left_idx_in;
   logic [IW-1:0] right_idx_ff, right_idx_in;
   logic          has_left_ff, has_left_in;
   logic          has_right_ff, has_right_in;
   logic          reject_ff, reject_in;
   link_type      head_ff, head_in;
   link_type      tail_ff, tail_in;
   logic [CW-1:0] length_ff, length_in;
   logic [IW-1:0] clear_ff, clear_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [IW-1:0] mem_raddr;
   logic [EW-1:0] mem_rbits;
   entry_type     rd_ent;

   logic          node_ok;
   logic [IW-1:0] nidx;
   logic [IW-1:0] aidx;
   logic          is_head;
   logic          is_insert;
   link_type      succ;
   link_type      null_link;
   logic          member;
   logic [CXW-1:0] cnt_wide;

   dll_node_ram #(
      .WIDTH (EW),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rbits)
   );

   assign rd_ent    = entry_type'(mem_rbits);
   assign node_ok   = in_pool(req_ff.node);
   assign nidx      = to_idx(req_ff.node);
   assign aidx      = to_idx(req_ff.anchor);
   assign is_head   = head_ff.valid && (head_ff.idx == nidx);
   assign is_insert = (req_ff.mode == MODE_INSERT);
   assign null_link = '0;
   assign succ      = req_ff.at_head ? head_ff : left_ent_ff.next;
   assign member    = node_ok && node_ent_ff.listed;
   assign cnt_wide  = CXW'(length_ff);

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      node_ent_in  = node_ent_ff;
      left_ent_in  = left_ent_ff;
      right_ent_in = right_ent_ff;
      left_idx_in  = left_idx_ff;
      right_idx_in = right_idx_ff;
      has_left_in  = has_left_ff;
      has_right_in = has_right_ff;
      reject_in    = reject_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      length_in    = length_ff;
      clear_in     = clear_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = nidx;
      mem_wdata    = '0;
      mem_raddr    = nidx;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
            if (clear_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clear_in = clear_ff + IW'(1);
            end
         end
         S_IDLE: begin
            mem_raddr = to_idx(req_bus.payload.node);
            if (req_bus.valid) begin
               req_in   = req_bus.payload;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            node_ent_in  = rd_ent;
            has_left_in  = 1'b0;
            has_right_in = 1'b0;
            reject_in    = 1'b1;
            state_in     = S_DONE;
            case (req_ff.mode)
               MODE_INSERT: begin
                  if (node_ok && !rd_ent.listed) begin
                     if (req_ff.at_head) begin
                        reject_in = 1'b0;
                        if (head_ff.valid) begin
                           right_idx_in = head_ff.idx;
                           has_right_in = 1'b1;
                           mem_raddr    = head_ff.idx;
                           state_in     = S_RIGHT;
                        end else begin
                           state_in = S_WR_N;
                        end
                     end else if (in_pool(req_ff.anchor)) begin
                        left_idx_in = aidx;
                        mem_raddr   = aidx;
                        state_in    = S_LEFT;
                     end
                  end
               end
               MODE_DELETE: begin
                  if (node_ok && rd_ent.listed) begin
                     reject_in = 1'b0;
                     if (is_head) begin
                        if (rd_ent.next.valid) begin
                           right_idx_in = rd_ent.next.idx;
                           has_right_in = 1'b1;
                           mem_raddr    = rd_ent.next.idx;
                           state_in     = S_RIGHT;
                        end else begin
                           state_in = S_WR_N;
                        end
                     end else if (rd_ent.prev.valid) begin
                        left_idx_in = rd_ent.prev.idx;
                        mem_raddr   = rd_ent.prev.idx;
                        state_in    = S_LEFT;
                     end else begin
                        state_in = S_WR_N;
                     end
                  end
               end
               MODE_READ: begin
                  reject_in = !(node_ok && rd_ent.listed);
               end
               default: begin
                  reject_in = 1'b1;
               end
            endcase
         end
         S_LEFT: begin
            left_ent_in = rd_ent;
            if (is_insert && !rd_ent.listed) begin
               state_in = S_DONE;
            end else begin
               reject_in   = 1'b0;
               has_left_in = 1'b1;
               if (is_insert ? rd_ent.next.valid : node_ent_ff.next.valid) begin
                  right_idx_in = is_insert ? rd_ent.next.idx : node_ent_ff.next.idx;
                  has_right_in = 1'b1;
                  mem_raddr    = right_idx_in;
                  state_in     = S_RIGHT;
               end else begin
                  state_in = S_WR_L;
               end
            end
         end
         S_RIGHT: begin
            right_ent_in = rd_ent;
            state_in     = has_left_ff ? S_WR_L : S_WR_R;
         end
         S_WR_L: begin
            mem_we         = 1'b1;
            mem_waddr      = left_idx_ff;
            mem_wdata      = left_ent_ff;
            mem_wdata.next = is_insert ? link_type'{1'b1, nidx} : node_ent_ff.next;
            state_in       = has_right_ff ? S_WR_R : S_WR_N;
         end
         S_WR_R: begin
            mem_we         = 1'b1;
            mem_waddr      = right_idx_ff;
            mem_wdata      = right_ent_ff;
            mem_wdata.prev = is_insert ? link_type'{1'b1, nidx} :
                             (is_head ? null_link : node_ent_ff.prev);
            state_in       = S_WR_N;
         end
         S_WR_N: begin
            mem_we    = 1'b1;
            mem_waddr = nidx;
            if (is_insert) begin
               mem_wdata.listed = 1'b1;
               mem_wdata.next   = succ;
               mem_wdata.prev   = req_ff.at_head ? null_link : link_type'{1'b1, aidx};
               if (!succ.valid) begin
                  tail_in = link_type'{1'b1, nidx};
               end
               if (req_ff.at_head) begin
                  head_in = link_type'{1'b1, nidx};
               end
               length_in = length_ff + CW'(1);
            end else begin
               mem_wdata = '0;
               if (is_head) begin
                  head_in = node_ent_ff.next;
                  if (!node_ent_ff.next.valid) begin
                     tail_in = null_link;
                  end
               end else if (node_ent_ff.prev.valid && !node_ent_ff.next.valid) begin
                  tail_in = node_ent_ff.prev;
               end
               if (length_ff != '0) begin
                  length_in = length_ff - CW'(1);
               end
            end
            node_ent_in = mem_wdata;
            state_in    = S_DONE;
         end
         S_DONE: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = reject_ff;
               rsp_in.next_node  = (member && node_ent_ff.next.valid) ?
                                   to_fld(node_ent_ff.next.idx) : '0;
               rsp_in.next_valid = member && node_ent_ff.next.valid;
               rsp_in.prev_node  = (member && node_ent_ff.prev.valid) ?
                                   to_fld(node_ent_ff.prev.idx) : '0;
               rsp_in.prev_valid = member && node_ent_ff.prev.valid;
               rsp_in.head_node  = head_ff.valid ? to_fld(head_ff.idx) : '0;
               rsp_in.head_valid = head_ff.valid;
               rsp_in.tail_node  = tail_ff.valid ? to_fld(tail_ff.idx) : '0;
               rsp_in.tail_valid = tail_ff.valid;
               rsp_in.count      = cnt_wide[COUNT_W-1:0];
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         has_left_ff  <= 1'b0;
         has_right_ff <= 1'b0;
         reject_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         has_left_ff  <= has_left_in;
         has_right_ff <= has_right_in;
         reject_ff    <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      node_ent_ff  <= node_ent_in;
      left_ent_ff  <= left_ent_in;
      right_ent_ff <= right_ent_in;
      left_idx_ff  <= left_idx_in;
      right_idx_ff <= right_idx_in;
      rsp_ff       <= rsp_in;
   end

   `ASSERT_ALWAYS(a_len_bound, clock, reset, length_ff <= CW'(NODES), "list length beyond pool")
   `ASSERT_IMPLIES(a_ends_agree, clock, reset, state_ff == S_IDLE, head_ff.valid == tail_ff.valid, "head and tail validity differ")
   `ASSERT_IMPLIES(a_empty_len, clock, reset, state_ff == S_IDLE, head_ff.valid == (length_ff != '0), "head validity disagrees with length")
   `ASSERT_IMPLIES(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff, "result during clearing pass")
   `ASSERT_NEXT(a_req_start, clock, reset, req_bus.valid && req_bus.ready, state_ff == S_NODE, "transfer did not start node read")

endmodule

>>> tb/doubly_linked_list_manager_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the doubly linked list manager: directed and random requests.
module doubly_linked_list_manager_test;
   import dll_pkg::*;

   localparam int POOL         = 256;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

   typedef struct packed {
      bit              valid;
      bit [NODE_W-1:0] idx;
   } link_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dll_chan_if #(.payload_type(req_type)) req_bus ();
   dll_chan_if #(.payload_type(rsp_type)) rsp_bus ();

   doubly_linked_list_manager dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // list as the block should hold it
   link_type succ_of [POOL];
   link_type pred_of [POOL];
   bit       on_list [POOL];
   link_type first_link;
   link_type last_link;
   int       list_len;

   // membership as planned when the requests are queued
   bit planned_on [POOL];
   int planned_len;

   req_type queued_reqs [$];
   rsp_type awaited_views [$];

   int total_reqs;
   int sent;
   int received;
   int failures;
   int cycle_count;
   int hold_left;
   bit hold_done;

   function automatic link_type link_to(bit [NODE_W-1:0] i);
      return '{valid: 1'b1, idx: i};
   endfunction

   // applies one request to the list and returns the view the block should report
   function automatic rsp_type step_list(req_type r);
      rsp_type  v;
      link_type succ;
      link_type nx;
      link_type pv;
      logic     rejected;
      v = '0;
      rejected = 1'b1;
      case (r.mode)
         MODE_INSERT: begin
            if (!on_list[r.node] && (r.at_head || on_list[r.anchor])) begin
               succ = r.at_head ? first_link : succ_of[r.anchor];
               succ_of[r.node] = succ;
               if (!succ.valid) last_link = link_to(r.node);
               else pred_of[succ.idx] = link_to(r.node);
               if (r.at_head) begin
                  pred_of[r.node] = '0;
                  first_link = link_to(r.node);
               end else begin
                  pred_of[r.node] = link_to(r.anchor);
                  succ_of[r.anchor] = link_to(r.node);
               end
               on_list[r.node] = 1'b1;
               list_len++;
               rejected = 1'b0;
            end
         end
         MODE_DELETE: begin
            if (on_list[r.node]) begin
               nx = succ_of[r.node];
               pv = pred_of[r.node];
               if (first_link.valid && first_link.idx == r.node) begin
                  first_link = nx;
                  if (!nx.valid) last_link = '0;
                  else pred_of[nx.idx] = '0;
               end else if (pv.valid) begin
                  succ_of[pv.idx] = nx;
                  if (!nx.valid) last_link = pv;
                  else pred_of[nx.idx] = pv;
               end
               succ_of[r.node] = '0;
               pred_of[r.node] = '0;
               on_list[r.node] = 1'b0;
               if (list_len > 0) list_len--;
               rejected = 1'b0;
            end
         end
         MODE_READ: rejected = !on_list[r.node];
         default: ;
      endcase
      v.status = rejected;
      if (on_list[r.node]) begin
         nx = succ_of[r.node];
         pv = pred_of[r.node];
         v.next_node  = nx.valid ? nx.idx : '0;
         v.next_valid = nx.valid;
         v.prev_node  = pv.valid ? pv.idx : '0;
         v.prev_valid = pv.valid;
      end
      v.head_node  = first_link.valid ? first_link.idx : '0;
      v.head_valid = first_link.valid;
      v.tail_node  = last_link.valid ? last_link.idx : '0;
      v.tail_valid = last_link.valid;
      v.count      = list_len[COUNT_W-1:0];
      return v;
   endfunction

   task automatic push_req(input logic [MODE_W-1:0] mode, input int node, input int anchor,
                           input bit at_head);
      req_type r;
      r.mode    = mode;
      r.node    = node[NODE_W-1:0];
      r.anchor  = anchor[NODE_W-1:0];
      r.at_head = at_head;
      queued_reqs.push_back(r);
      if (mode == MODE_INSERT && !planned_on[r.node] && (at_head || planned_on[r.anchor])) begin
         planned_on[r.node] = 1'b1;
         planned_len++;
      end else if (mode == MODE_DELETE && planned_on[r.node]) begin
         planned_on[r.node] = 1'b0;
         planned_len--;
      end
   endtask

   function automatic int pick_node(bit listed);
      int n;
      do n = $urandom_range(POOL - 1); while (planned_on[n] != listed);
      return n;
   endfunction

   task automatic plan_insert();
      int node;
      int anchor;
      bit at_head;
      if (planned_len == POOL) begin
         push_req(MODE_INSERT, $urandom_range(POOL - 1), $urandom_range(POOL - 1),
                  1'($urandom_range(1)));
         return;
      end
      node = pick_node(1'b0);
      at_head = planned_len == 0 || $urandom_range(3) == 0;
      anchor = at_head ? $urandom_range(POOL - 1) : pick_node(1'b1);
      push_req(MODE_INSERT, node, anchor, at_head);
   endtask

   // mostly well-formed requests, some noise that breaks the membership rules
   task automatic plan_random(input int n, input int ins_pct, input int del_pct);
      int roll;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 8)
            push_req(MODE_W'($urandom_range(3)), $urandom_range(POOL - 1),
                     $urandom_range(POOL - 1), 1'($urandom_range(1)));
         else if (roll < 8 + ins_pct)
            plan_insert();
         else if (planned_len == 0)
            push_req(MODE_READ, $urandom_range(POOL - 1), $urandom_range(POOL - 1),
                     1'($urandom_range(1)));
         else if (roll < 8 + ins_pct + del_pct)
            push_req(MODE_DELETE, pick_node(1'b1), $urandom_range(POOL - 1),
                     1'($urandom_range(1)));
         else
            push_req(MODE_READ, pick_node(1'b1), $urandom_range(POOL - 1),
                     1'($urandom_range(1)));
      end
   endtask

   // idling by thirds: sender light / receiver heavy, then swapped, then none
   function automatic int idle_pct(int done, bit receiver);
      case (done * 3 / total_reqs)
         0: return receiver ? 70 : 18;
         1: return receiver ? 18 : 70;
         default: return 0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_view(input rsp_type got);
      rsp_type want;
      received++;
      if (awaited_views.size() == 0) begin
         $error("result transfer with no request outstanding");
         failures++;
         return;
      end
      want = awaited_views.pop_front();
      check_field("status", COUNT_W'(want.status), COUNT_W'(got.status));
      check_field("next_node", COUNT_W'(want.next_node), COUNT_W'(got.next_node));
      check_field("next_valid", COUNT_W'(want.next_valid), COUNT_W'(got.next_valid));
      check_field("prev_node", COUNT_W'(want.prev_node), COUNT_W'(got.prev_node));
      check_field("prev_valid", COUNT_W'(want.prev_valid), COUNT_W'(got.prev_valid));
      check_field("head_node", COUNT_W'(want.head_node), COUNT_W'(got.head_node));
      check_field("head_valid", COUNT_W'(want.head_valid), COUNT_W'(got.head_valid));
      check_field("tail_node", COUNT_W'(want.tail_node), COUNT_W'(got.tail_node));
      check_field("tail_valid", COUNT_W'(want.tail_valid), COUNT_W'(got.tail_valid));
      check_field("count", want.count, got.count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_views.push_back(step_list(req_bus.payload));
            sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (queued_reqs.size() > 0 && $urandom_range(99) >= idle_pct(sent, 1'b0)) begin
               req_bus.valid   <= 1'b1;
               req_bus.payload <= queued_reqs.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) compare_view(rsp_bus.payload);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && received >= total_reqs * 2 / 3 + 30) begin
            // long back-pressure so the block fills up and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= $urandom_range(99) >= idle_pct(received, 1'b1);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;

      // empty list, unknown mode, then build 255,128,0,1
      push_req(MODE_READ, 0, 0, 1'b0);
      push_req(MODE_DELETE, 255, 255, 1'b1);
      push_req(MODE_INSERT, 0, 0, 1'b0);
      push_req(MODE_UNKNOWN, 255, 255, 1'b1);
      push_req(MODE_INSERT, 0, 255, 1'b1);
      push_req(MODE_INSERT, 255, 0, 1'b1);
      push_req(MODE_INSERT, 128, 255, 1'b0);
      push_req(MODE_INSERT, 1, 0, 1'b0);
      // broken inserts, then reads of listed nodes
      push_req(MODE_INSERT, 128, 0, 1'b1);
      push_req(MODE_INSERT, 7, 9, 1'b0);
      push_req(MODE_INSERT, 7, 7, 1'b0);
      push_req(MODE_READ, 128, 85, 1'b1);
      push_req(MODE_READ, 255, 0, 1'b0);
      push_req(MODE_READ, 1, 0, 1'b0);
      // unlink middle, head, tail, a node not listed, then rebuild and empty
      push_req(MODE_DELETE, 128, 0, 1'b0);
      push_req(MODE_DELETE, 255, 0, 1'b0);
      push_req(MODE_DELETE, 1, 0, 1'b0);
      push_req(MODE_DELETE, 1, 0, 1'b0);
      push_req(MODE_READ, 1, 0, 1'b0);
      push_req(MODE_INSERT, 170, 85, 1'b1);
      push_req(MODE_INSERT, 85, 0, 1'b0);
      push_req(MODE_UNKNOWN, 0, 170, 1'b0);
      push_req(MODE_DELETE, 0, 0, 1'b0);
      push_req(MODE_DELETE, 170, 0, 1'b0);
      push_req(MODE_DELETE, 85, 0, 1'b0);

      plan_random(220, 55, 20);
      while (planned_len < POOL) plan_insert();
      plan_random(25, 40, 0);
      plan_random(170, 20, 60);
      plan_random(80, 35, 30);
      total_reqs = queued_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (sent < total_reqs || awaited_views.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dll_pkg.sv
rtl/dll_chan_if.sv
rtl/dll_node_ram.sv
rtl/doubly_linked_list_manager.sv
tb/doubly_linked_list_manager_test.sv
